@@ hdl/dog_scale_space_extrema_detector_unit_defines.svh @@
// Assertion macros used by the checker file.
`ifndef DOG_SCALE_SPACE_EXTREMA_DETECTOR_UNIT_DEFINES_SVH
`define DOG_SCALE_SPACE_EXTREMA_DETECTOR_UNIT_DEFINES_SVH

// Clocked assertion, masked while reset is asserted.
`define DOGEXT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define DOGEXT_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/dogext_pkg.sv @@
package dogext_pkg;

    localparam int ROW_W      = 12;
    localparam int COL_OUT_W  = 10;
    localparam int FW_W       = 11;
    localparam int FH_W       = 12;
    localparam int CFG_DW     = 12;
    localparam int CFG_AW     = 1;
    localparam int NUM_SCALES = 3;

    localparam logic [FW_W-1:0] FW_RESET = 11'd640;
    localparam logic [FH_W-1:0] FH_RESET = 12'd480;

    typedef enum logic [CFG_AW-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic                 full;
        logic [ROW_W-1:0]     kp_row;
        logic [COL_OUT_W-1:0] kp_col;
    } t_kp_meta;

endpackage

@@ hdl/dogext_pix_if.sv @@
interface dogext_pix_if #(
    parameter int PIXEL_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [PIXEL_BITS-1:0] dog_below;
    logic signed [PIXEL_BITS-1:0] dog_center;
    logic signed [PIXEL_BITS-1:0] dog_above;
    logic                         start_of_frame;

    modport source (
        output valid, dog_below, dog_center, dog_above, start_of_frame,
        input  ready
    );

    modport sink (
        input  valid, dog_below, dog_center, dog_above, start_of_frame,
        output ready
    );
endinterface

@@ hdl/dogext_kp_if.sv @@
interface dogext_kp_if;
    import dogext_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ROW_W-1:0]     keypoint_row;
    logic [COL_OUT_W-1:0] keypoint_col;
    logic                 is_minimum;

    modport source (
        output valid, keypoint_row, keypoint_col, is_minimum,
        input  ready
    );

    modport sink (
        input  valid, keypoint_row, keypoint_col, is_minimum,
        output ready
    );
endinterface

@@ hdl/dogext_pos.sv @@
module dogext_pos #(
    parameter int MAX_WIDTH = 1024,
    parameter int WINDOW    = 3,
    localparam int AW       = $clog2(MAX_WIDTH)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dogext_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [dogext_pkg::CFG_DW-1:0]   i_cfg_wdata,
    input  logic                            i_accept,
    input  logic                            i_sof,
    output logic [AW-1:0]                   o_addr,
    output dogext_pkg::t_kp_meta            o_meta
);
    import dogext_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH + 1);
    localparam int EW   = (CW > FW_W) ? CW : FW_W;
    localparam int HALF = WINDOW / 2;
    localparam int LAG  = WINDOW - 1 - HALF;
    localparam logic [EW-1:0] MAXW = EW'(MAX_WIDTH);

    logic [FW_W-1:0]  r_frame_width;
    logic [FH_W-1:0]  r_frame_height;
    logic [ROW_W-1:0] r_row, n_row;
    logic [CW-1:0]    r_col, n_col;

    logic [EW-1:0]    eff_w;
    logic [FH_W-1:0]  eff_h;
    logic [ROW_W-1:0] row_a;
    logic [CW-1:0]    col_a;
    logic [CW-1:0]    col_inc;

    always_comb begin
        eff_w = EW'(r_frame_width);
        if (r_frame_width == '0) begin
            eff_w = EW'(1);
        end else if (eff_w > MAXW) begin
            eff_w = MAXW;
        end
        eff_h = (r_frame_height == '0) ? FH_W'(1) : r_frame_height;

        // position of this beat
        row_a = r_row;
        col_a = r_col;
        if (i_sof) begin
            row_a = '0;
            col_a = '0;
        end else begin
            if (EW'(r_col) >= eff_w) begin
                col_a = '0;
                row_a = r_row + ROW_W'(1);
            end
            if (row_a >= eff_h) begin
                row_a = '0;
            end
        end

        // position of the next beat
        col_inc = col_a + CW'(1);
        n_col   = col_inc;
        n_row   = row_a;
        if (EW'(col_inc) >= eff_w) begin
            n_col = '0;
            n_row = row_a + ROW_W'(1);
            if (n_row >= eff_h) begin
                n_row = '0;
            end
        end

        if (col_a >= CW'(MAX_WIDTH)) begin
            o_addr = AW'(MAX_WIDTH - 1);
        end else begin
            o_addr = col_a[AW-1:0];
        end

        o_meta.full   = (row_a >= ROW_W'(WINDOW - 1)) && (col_a >= CW'(WINDOW - 1));
        o_meta.kp_row = row_a - ROW_W'(LAG);
        o_meta.kp_col = COL_OUT_W'(col_a - CW'(LAG));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FW_RESET;
            r_frame_height <= FH_RESET;
            r_row          <= '0;
            r_col          <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_addr))
                    CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata[FW_W-1:0];
                    CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata[FH_W-1:0];
                    default: ;
                endcase
            end
            if (i_accept) begin
                r_row <= n_row;
                r_col <= n_col;
            end
        end
    end
endmodule

@@ hdl/dogext_line_store.sv @@
module dogext_line_store #(
    parameter int MAX_WIDTH  = 1024,
    parameter int WINDOW     = 3,
    parameter int PIXEL_BITS = 16,
    localparam int AW        = $clog2(MAX_WIDTH)
) (
    input  logic                                                      i_clk,
    input  logic                                                      i_rst_n,
    input  logic                                                      i_en,
    input  logic                                                      i_valid,
    input  logic [AW-1:0]                                             i_addr,
    input  logic [dogext_pkg::NUM_SCALES-1:0][PIXEL_BITS-1:0]         i_px,
    input  dogext_pkg::t_kp_meta                                      i_meta,
    output logic                                                      o_valid,
    output logic [WINDOW-1:0][dogext_pkg::NUM_SCALES-1:0][PIXEL_BITS-1:0] o_col,
    output dogext_pkg::t_kp_meta                                      o_meta
);
    import dogext_pkg::*;

    // one entry = WINDOW-1 stored rows of one column, row 0 newest
    typedef logic [NUM_SCALES-1:0][PIXEL_BITS-1:0]   t_trip;
    typedef logic [WINDOW-2:0][NUM_SCALES-1:0][PIXEL_BITS-1:0] t_entry;

    t_entry   mem [MAX_WIDTH];
    t_entry   r_rdata;
    t_entry   r_fwd_data;
    logic     r_fwd_hit;
    logic     r_p1_valid;
    logic [AW-1:0] r_p1_addr;
    t_trip    r_p1_px;
    t_kp_meta r_p1_meta;

    t_entry   old_entry;
    t_entry   new_entry;

    always_comb begin
        old_entry    = r_fwd_hit ? r_fwd_data : r_rdata;
        new_entry[0] = r_p1_px;
        for (int k = 1; k < WINDOW - 1; k++) begin
            new_entry[k] = old_entry[k-1];
        end
        for (int r = 0; r < WINDOW - 1; r++) begin
            o_col[r] = old_entry[WINDOW-2-r];
        end
        o_col[WINDOW-1] = r_p1_px;
    end

    assign o_valid = r_p1_valid;
    assign o_meta  = r_p1_meta;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_p1_valid) begin
                mem[r_p1_addr] <= new_entry;
            end
            r_rdata <= mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (i_en) begin
            r_p1_valid <= i_valid;
        end
    end

    // same column back to back: read raced the write, take the written entry
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1_addr  <= i_addr;
            r_p1_px    <= i_px;
            r_p1_meta  <= i_meta;
            r_fwd_hit  <= r_p1_valid && (r_p1_addr == i_addr);
            r_fwd_data <= new_entry;
        end
    end
endmodule

@@ hdl/dogext_extrema.sv @@
module dogext_extrema #(
    parameter int WINDOW     = 3,
    parameter int PIXEL_BITS = 16
) (
    input  logic                                                          i_clk,
    input  logic                                                          i_rst_n,
    input  logic                                                          i_valid,
    input  logic [WINDOW-1:0][dogext_pkg::NUM_SCALES-1:0][PIXEL_BITS-1:0] i_col,
    input  dogext_pkg::t_kp_meta                                          i_meta,
    output logic                                                          o_en,
    dogext_kp_if.source                                                   o_kp
);
    import dogext_pkg::*;

    localparam int HALF = WINDOW / 2;

    logic [NUM_SCALES-1:0][WINDOW-1:0][WINDOW-1:0][PIXEL_BITS-1:0] r_win;
    logic                 r_p2_valid;
    t_kp_meta             r_p2_meta;
    logic                 r_out_valid;
    logic [ROW_W-1:0]     r_kp_row;
    logic [COL_OUT_W-1:0] r_kp_col;
    logic                 r_is_min;

    logic signed [PIXEL_BITS-1:0] center;
    logic signed [PIXEL_BITS-1:0] nb;
    logic                         gt_all;
    logic                         lt_all;

    assign o_en = !r_out_valid || o_kp.ready;

    always_ff @(posedge i_clk) begin
        if (o_en && i_valid) begin
            for (int s = 0; s < NUM_SCALES; s++) begin
                for (int r = 0; r < WINDOW; r++) begin
                    for (int k = 0; k < WINDOW - 1; k++) begin
                        r_win[s][r][k] <= r_win[s][r][k+1];
                    end
                    r_win[s][r][WINDOW-1] <= i_col[r][s];
                end
            end
        end
    end

    always_comb begin
        center = $signed(r_win[1][HALF][HALF]);
        nb     = '0;
        gt_all = 1'b1;
        lt_all = 1'b1;
        for (int s = 0; s < NUM_SCALES; s++) begin
            for (int r = 0; r < WINDOW; r++) begin
                for (int k = 0; k < WINDOW; k++) begin
                    if (!(s == 1 && r == HALF && k == HALF)) begin
                        nb = $signed(r_win[s][r][k]);
                        if (!(center > nb)) gt_all = 1'b0;
                        if (!(center < nb)) lt_all = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (o_en) begin
            r_p2_valid  <= i_valid;
            r_out_valid <= r_p2_valid && r_p2_meta.full && (gt_all || lt_all);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_p2_meta <= i_meta;
            r_kp_row  <= r_p2_meta.kp_row;
            r_kp_col  <= r_p2_meta.kp_col;
            r_is_min  <= lt_all;
        end
    end

    assign o_kp.valid        = r_out_valid;
    assign o_kp.keypoint_row = r_kp_row;
    assign o_kp.keypoint_col = r_kp_col;
    assign o_kp.is_minimum   = r_is_min;
endmodule

@@ hdl/dog_scale_space_extrema_detector_unit.sv @@
// 3x3x3 scale-space extremum detector over three DoG images streamed in raster
// order, one co-located pixel triple per beat. Sustained rate is one pixel per
// clock; a keypoint passes the line-store, window and output registers after
// the pixel completing its window (bottom-right). The two previous rows of all
// three scales sit in one MAX_WIDTH-deep memory, one entry per column, which is
// read and written back once per beat; a back-to-back hit on the same column
// (frame width of one, or a restart) is forwarded around the memory. The pixel
// side stalls only while a keypoint waits on the output. Frame size comes from
// the two config registers, written while the stream is idle; positions wrap
// at the end of a frame and restart on start_of_frame.
module dog_scale_space_extrema_detector_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int WINDOW     = 3,
    parameter int PIXEL_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dogext_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [dogext_pkg::CFG_DW-1:0] i_cfg_wdata,
    dogext_pix_if.sink                    i_pix,
    dogext_kp_if.source                   o_kp
);
    import dogext_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    logic                                              en;
    logic                                              accept;
    logic [AW-1:0]                                     rd_addr;
    t_kp_meta                                          meta0;
    t_kp_meta                                          meta1;
    logic [NUM_SCALES-1:0][PIXEL_BITS-1:0]             px;
    logic                                              col_valid;
    logic [WINDOW-1:0][NUM_SCALES-1:0][PIXEL_BITS-1:0] col;

    assign i_pix.ready = en;
    assign accept      = i_pix.valid && en;
    assign px          = {i_pix.dog_above, i_pix.dog_center, i_pix.dog_below};

    dogext_pos #(
        .MAX_WIDTH (MAX_WIDTH),
        .WINDOW    (WINDOW)
    ) u_pos (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_sof       (i_pix.start_of_frame),
        .o_addr      (rd_addr),
        .o_meta      (meta0)
    );

    dogext_line_store #(
        .MAX_WIDTH  (MAX_WIDTH),
        .WINDOW     (WINDOW),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (accept),
        .i_addr  (rd_addr),
        .i_px    (px),
        .i_meta  (meta0),
        .o_valid (col_valid),
        .o_col   (col),
        .o_meta  (meta1)
    );

    dogext_extrema #(
        .WINDOW     (WINDOW),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_extrema (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (col_valid),
        .i_col   (col),
        .i_meta  (meta1),
        .o_en    (en),
        .o_kp    (o_kp)
    );
endmodule

@@ hdl/dogext_checker.sv @@
`include "dog_scale_space_extrema_detector_unit_defines.svh"

module dogext_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_pix_ready,
    input  logic                             i_kp_valid,
    input  logic                             i_kp_ready,
    input  logic [dogext_pkg::ROW_W-1:0]     i_kp_row,
    input  logic [dogext_pkg::COL_OUT_W-1:0] i_kp_col,
    input  logic                             i_kp_is_minimum
);
    `DOGEXT_ASSERT(a_kp_hold, i_clk, i_rst_n, i_kp_valid && !i_kp_ready |=> i_kp_valid && $stable(i_kp_row) && $stable(i_kp_col) && $stable(i_kp_is_minimum), "keypoint beat changed while stalled")
    `DOGEXT_ASSERT(a_stall_back, i_clk, i_rst_n, i_kp_valid && !i_kp_ready |-> !i_pix_ready, "pixel taken while keypoint stalled")
    `DOGEXT_ASSERT_NR(a_reset_idle, i_clk, !i_rst_n |=> !i_kp_valid, "keypoint valid after reset")
    `DOGEXT_ASSERT(a_kp_inside, i_clk, i_rst_n, i_kp_valid |-> i_kp_row != '0 && i_kp_col != '0, "keypoint on frame border")
endmodule

bind dog_scale_space_extrema_detector_unit dogext_checker u_dogext_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_pix_ready     (i_pix.ready),
    .i_kp_valid      (o_kp.valid),
    .i_kp_ready      (o_kp.ready),
    .i_kp_row        (o_kp.keypoint_row),
    .i_kp_col        (o_kp.keypoint_col),
    .i_kp_is_minimum (o_kp.is_minimum)
);
